// ===== rtl/core/csvfs_pkg.sv =====
// csvfs_pkg: types, constants and the parser transition table of the CSV field splitter.
// No dependencies; used by csv_field_splitter.
`default_nettype none

package csvfs_pkg;

  localparam int unsigned POS_W               = 16;
  localparam int unsigned CHAR_W              = 8;
  localparam int unsigned CFG_INDEX_W         = 8;
  localparam int unsigned MAX_LINE_LENGTH_DEF = 65535;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'd10;
  localparam logic [CHAR_W-1:0] SEP_RESET     = 8'd44;
  localparam logic [CHAR_W-1:0] QUOTE_RESET   = 8'd34;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE     = 8'd1;

  // Parser states; ROW_END and QUOTE_ERR are only ever transition targets.
  typedef enum logic [2:0] {
    ST_PLAIN       = 3'd0,
    ST_AFTER_SEP   = 3'd1,
    ST_QUOTE_OPEN  = 3'd2,
    ST_QUOTED      = 3'd3,
    ST_QUOTE_CLOSE = 3'd4,
    ST_ROW_END     = 3'd5,
    ST_QUOTE_ERR   = 3'd6
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_SEP     = 3'd0,
    EV_QUOTE   = 3'd1,
    EV_NEWLINE = 3'd2,
    EV_PLAIN   = 3'd3,
    EV_END     = 3'd4
  } char_event_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OPEN_QUOTE = 2'd1,
    STAT_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] field_start;
    logic [POS_W-1:0] field_length;
    logic             has_field;
    logic             row_last;
    status_t          status;
  } result_t;

  function automatic parse_state_t next_state(parse_state_t st, char_event_t ev);
    parse_state_t ns;
    ns = ST_PLAIN;
    unique case (st)
      ST_QUOTE_OPEN, ST_QUOTED: begin
        case (ev)
          EV_QUOTE: ns = ST_QUOTE_CLOSE;
          EV_END:   ns = ST_QUOTE_ERR;
          default:  ns = ST_QUOTED;
        endcase
      end
      ST_QUOTE_CLOSE: begin
        case (ev)
          EV_SEP:   ns = ST_AFTER_SEP;
          EV_QUOTE: ns = ST_QUOTED;
          EV_PLAIN: ns = ST_PLAIN;
          default:  ns = ST_ROW_END;
        endcase
      end
      default: begin
        case (ev)
          EV_SEP:   ns = ST_AFTER_SEP;
          EV_QUOTE: ns = ST_QUOTE_OPEN;
          EV_PLAIN: ns = ST_PLAIN;
          default:  ns = ST_ROW_END;
        endcase
      end
    endcase
    return ns;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csv_field_splitter.sv =====
// csv_field_splitter: splits a stream of line bytes into field offsets and lengths.
// Depends on csvfs_pkg (types, constants, transition table).
`default_nettype none

// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+-------------------------------------------
// in_      | in  | in_tvalid / in_tready | tdata: char_code; tuser: end_of_line
// out_     | out | out_tvalid/out_tready | tdata: field_start, field_length;
//          |     |                       | tuser: has_field, status; tlast: row_last
// cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (separator, quote)
//
// One byte per cycle while in_tready is high: classify, table lookup and the position
// compare/subtract sit between the parser state registers and the result register,
// so an item is taken in every such cycle and its result (if any) is registered.
// A result register plus one skid entry decouple the sides; in_tready drops only
// while the skid entry is occupied. cfg_ready is always high.
// Synchronous active-low reset clears the parser, the buffers and loads the default
// separator (comma) and quote (double quote).

module csv_field_splitter #(
  parameter int unsigned MAX_LINE_LENGTH = csvfs_pkg::MAX_LINE_LENGTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request in: tdata[7:0] char_code; tuser end_of_line
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,
  input  wire logic                                in_tuser,
  // result out: tdata[15:0] field_start, [31:16] field_length;
  // tuser[0] has_field, [2:1] status
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [31:0]                              out_tdata,
  output logic [2:0]                               out_tuser,
  output logic                                     out_tlast,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [csvfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [csvfs_pkg::CHAR_W-1:0]        cfg_data
);

  localparam int unsigned POS_W = csvfs_pkg::POS_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE_LENGTH);

  // configuration
  logic [csvfs_pkg::CHAR_W-1:0] sep_char_r;
  logic [csvfs_pkg::CHAR_W-1:0] quote_char_r;

  // parser state
  csvfs_pkg::parse_state_t state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic             open_r, open_nxt;
  logic             row_fin_r, row_fin_nxt;

  // result buffering
  logic                 out_valid_r;
  csvfs_pkg::result_t   out_r;
  logic                 skid_valid_r;
  csvfs_pkg::result_t   skid_r;

  logic                     accept;
  logic                     eol;
  logic [7:0]               ch;
  csvfs_pkg::char_event_t   ev;
  csvfs_pkg::parse_state_t  ns;
  logic                     go_table;
  logic                     rearm;
  logic                     res_valid;
  csvfs_pkg::result_t       res;
  logic [POS_W-1:0]         close_pos;
  logic                     out_take;

  assign accept    = in_tvalid & in_tready;
  assign eol       = in_tuser;
  assign ch        = in_tdata;
  assign cfg_ready = 1'b1;
  assign in_tready = ~skid_valid_r;
  assign out_take  = out_valid_r & out_tready;

  // Classify the byte: separator beats quote when both registers match.
  always_comb begin
    if (eol) begin
      ev = csvfs_pkg::EV_END;
    end else if (ch == sep_char_r) begin
      ev = csvfs_pkg::EV_SEP;
    end else if (ch == quote_char_r) begin
      ev = csvfs_pkg::EV_QUOTE;
    end else if (ch == csvfs_pkg::NEWLINE_CODE) begin
      ev = csvfs_pkg::EV_NEWLINE;
    end else begin
      ev = csvfs_pkg::EV_PLAIN;
    end
  end

  assign ns = csvfs_pkg::next_state(state_r, ev);

  // The table runs unless the row is already done, the line is empty, or too long.
  assign go_table = accept & ~row_fin_r &
                    (eol ? (pos_r != '0) : (pos_r < MAX_POS));

  // The end item always rearms except when it drives a normal table step that
  // stays inside the row (never happens: END only leads to row end or error).
  assign rearm = accept & eol;

  // Next parser state.
  always_comb begin
    state_nxt = state_r;
    if (rearm) begin
      state_nxt = csvfs_pkg::ST_PLAIN;
    end else if (go_table) begin
      if (ns != csvfs_pkg::ST_ROW_END && ns != csvfs_pkg::ST_QUOTE_ERR) begin
        state_nxt = ns;
      end
    end
  end

  // A recorded closing quote counts only if set (nonzero) and not before the start.
  assign close_pos = (end_r == '0 || end_r < start_r) ? pos_r : end_r;

  // Position tracking and result generation.
  always_comb begin
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    open_nxt    = open_r;
    row_fin_nxt = row_fin_r;
    res_valid   = 1'b0;
    res         = '0;
    res.status  = csvfs_pkg::STAT_OK;

    if (accept && !row_fin_r) begin
      if (eol && pos_r == '0) begin
        // empty line: bare row end
        res_valid    = 1'b1;
        res.row_last = 1'b1;
      end else if (!eol && pos_r >= MAX_POS) begin
        res_valid    = 1'b1;
        res.row_last = 1'b1;
        res.status   = csvfs_pkg::STAT_TOO_LONG;
        row_fin_nxt  = 1'b1;
      end
    end

    if (go_table) begin
      if (!eol) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      unique case (ns)
        csvfs_pkg::ST_QUOTE_CLOSE: begin
          end_nxt = pos_r;
        end
        csvfs_pkg::ST_PLAIN, csvfs_pkg::ST_QUOTED: begin
          if (!open_r) begin
            start_nxt = pos_r;
            open_nxt  = 1'b1;
          end
        end
        csvfs_pkg::ST_QUOTE_OPEN: begin
        end
        csvfs_pkg::ST_QUOTE_ERR: begin
          res_valid    = 1'b1;
          res.row_last = 1'b1;
          res.status   = csvfs_pkg::STAT_OPEN_QUOTE;
        end
        default: begin
          // field closes on a separator or a row end
          res_valid     = 1'b1;
          res.has_field = 1'b1;
          res.row_last  = (ns == csvfs_pkg::ST_ROW_END);
          if (open_r) begin
            res.field_start  = start_r;
            res.field_length = close_pos - start_r;
          end
          open_nxt  = 1'b0;
          start_nxt = '0;
          end_nxt   = '0;
          if (ns == csvfs_pkg::ST_ROW_END && !eol) begin
            row_fin_nxt = 1'b1;
          end
        end
      endcase
    end

    if (rearm) begin
      pos_nxt     = '0;
      start_nxt   = '0;
      end_nxt     = '0;
      open_nxt    = 1'b0;
      row_fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_char_r   <= csvfs_pkg::SEP_RESET;
      quote_char_r <= csvfs_pkg::QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csvfs_pkg::CFG_SEPARATOR: sep_char_r   <= cfg_data;
        csvfs_pkg::CFG_QUOTE:     quote_char_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= csvfs_pkg::ST_PLAIN;
      pos_r     <= '0;
      start_r   <= '0;
      end_r     <= '0;
      open_r    <= 1'b0;
      row_fin_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      open_r    <= open_nxt;
      row_fin_r <= row_fin_nxt;
    end
  end

  // Result register with one skid entry; the skid drains first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.field_length, out_r.field_start};
  assign out_tuser  = {out_r.status, out_r.has_field};
  assign out_tlast  = out_r.row_last;

endmodule

`default_nettype wire

// ===== verif/tb_csv_field_splitter.sv =====
// tb_csv_field_splitter: self-checking testbench for csv_field_splitter.
// Drives bytes and end items, predicts or types in every result and checks them in order.
// Depends on csvfs_pkg and csv_field_splitter only.
`timescale 1ns / 100ps

module tb_csv_field_splitter;

  localparam int NUM_PROBES   = 23;
  localparam int NUM_PHASES   = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;

  localparam csvfs_pkg::result_t NO_RES = '0;

  // One directed request, plus the result typed in where it is obvious
  typedef struct packed {
    logic [7:0]         ch;
    logic               eol;
    logic               pinned;   // use the typed result below instead of the predictor's
    logic               has;      // typed: one result expected
    csvfs_pkg::result_t res;
  } probe_row_t;

  // Default separator (comma) and quote (double quote) are active for the whole table.
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    // empty line
    {8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b1, csvfs_pkg::STAT_OK},
    {8'h61, 1'b0, 1'b0, 1'b0, NO_RES},
    // closes "a"
    {csvfs_pkg::SEP_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    // empty field
    {csvfs_pkg::SEP_RESET, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0, csvfs_pkg::STAT_OK},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    {8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    // doubled quote kept
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    // row ends on newline
    {csvfs_pkg::NEWLINE_CODE, 1'b0, 1'b0, 1'b0, NO_RES},
    // dropped after row end
    {8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
    // rearm, no result
    {8'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    // field opens after close
    {8'h78, 1'b0, 1'b0, 1'b0, NO_RES},
    {8'h78, 1'b0, 1'b0, 1'b0, NO_RES},
    // stale close is ignored
    {csvfs_pkg::SEP_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    {csvfs_pkg::QUOTE_RESET, 1'b0, 1'b0, 1'b0, NO_RES},
    {8'h71, 1'b0, 1'b0, 1'b0, NO_RES},
    {8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b1, csvfs_pkg::STAT_OPEN_QUOTE},
    {csvfs_pkg::SEP_RESET, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0, csvfs_pkg::STAT_OK},
    // empty last field
    {8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b1, csvfs_pkg::STAT_OK}
  };

  // Register settings per random phase: odd bytes, both extremes, separator equal to
  // quote, newline as separator and as quote; the last phase returns to the defaults.
  localparam logic [7:0] SEP_SET [NUM_PHASES] =
    '{8'h3B, 8'h00, 8'hFF, 8'h09, csvfs_pkg::NEWLINE_CODE, csvfs_pkg::SEP_RESET, 8'h7C,
      csvfs_pkg::SEP_RESET};
  localparam logic [7:0] QUOTE_SET [NUM_PHASES] =
    '{8'h27, 8'hFF, 8'h00, 8'h09, csvfs_pkg::QUOTE_RESET, csvfs_pkg::NEWLINE_CODE, 8'h5E,
      csvfs_pkg::QUOTE_RESET};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] char_code
  logic        in_tuser = 1'b0;      // [0] end_of_line
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [15:0] field_start, [31:16] field_length
  logic [2:0]  out_tuser;            // [0] has_field, [2:1] status
  logic        out_tlast;            // row_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [csvfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [csvfs_pkg::CHAR_W-1:0]      cfg_data = '0;

  // Predictor state: a private copy of the registers and of the line parser
  logic [7:0]              sep_cfg = csvfs_pkg::SEP_RESET;
  logic [7:0]              quote_cfg = csvfs_pkg::QUOTE_RESET;
  csvfs_pkg::parse_state_t line_st;
  logic [15:0]             line_pos;
  logic [15:0]             open_start;
  logic [15:0]             close_pos;           // 0 while no closing quote is recorded
  logic                    field_live;
  logic                    row_done;

  csvfs_pkg::result_t field_q [$];   // predicted results, oldest first
  csvfs_pkg::result_t seen_res;
  csvfs_pkg::result_t want_res;
  int      mismatch_cnt = 0;
  int      parsed_chars = 0;
  int      out_hold = 0;
  bit      no_idle = 1'b0;

  csv_field_splitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop far beyond the slowest legal run (every request and result fully stalled).
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void restart_line();
    line_st    = csvfs_pkg::ST_PLAIN;
    line_pos   = '0;
    open_start = '0;
    close_pos  = '0;
    field_live = 1'b0;
    row_done   = 1'b0;
  endfunction

  // Advance the parser copy by one request; return 1 with the result if one is due.
  function automatic bit split_char(input logic [7:0] ch, input logic eol,
                                    output csvfs_pkg::result_t r);
    logic [15:0]             cur;
    logic [15:0]             stop;
    csvfs_pkg::char_event_t  ev;
    csvfs_pkg::parse_state_t nx;
    r   = '0;
    cur = line_pos;
    if (eol) begin
      if (row_done) begin
        restart_line();
        return 1'b0;
      end
      if (line_pos == 16'd0) begin
        r.row_last = 1'b1;
        restart_line();
        return 1'b1;
      end
      ev = csvfs_pkg::EV_END;
    end else begin
      if (row_done) return 1'b0;
      if (line_pos >= csvfs_pkg::MAX_LINE_LENGTH_DEF) begin
        r.row_last = 1'b1;
        r.status   = csvfs_pkg::STAT_TOO_LONG;
        row_done   = 1'b1;
        return 1'b1;
      end
      // separator wins over quote, quote over newline
      if (ch == sep_cfg)                      ev = csvfs_pkg::EV_SEP;
      else if (ch == quote_cfg)               ev = csvfs_pkg::EV_QUOTE;
      else if (ch == csvfs_pkg::NEWLINE_CODE) ev = csvfs_pkg::EV_NEWLINE;
      else                                    ev = csvfs_pkg::EV_PLAIN;
      line_pos = cur + 16'd1;
    end

    if (line_st == csvfs_pkg::ST_QUOTE_OPEN || line_st == csvfs_pkg::ST_QUOTED) begin
      if (ev == csvfs_pkg::EV_QUOTE)     nx = csvfs_pkg::ST_QUOTE_CLOSE;
      else if (ev == csvfs_pkg::EV_END)  nx = csvfs_pkg::ST_QUOTE_ERR;
      else                               nx = csvfs_pkg::ST_QUOTED;
    end else if (ev == csvfs_pkg::EV_SEP) begin
      nx = csvfs_pkg::ST_AFTER_SEP;
    end else if (ev == csvfs_pkg::EV_PLAIN) begin
      nx = csvfs_pkg::ST_PLAIN;
    end else if (ev == csvfs_pkg::EV_QUOTE) begin
      nx = (line_st == csvfs_pkg::ST_QUOTE_CLOSE) ? csvfs_pkg::ST_QUOTED
                                                  : csvfs_pkg::ST_QUOTE_OPEN;
    end else begin
      nx = csvfs_pkg::ST_ROW_END;
    end

    case (nx)
      csvfs_pkg::ST_QUOTE_CLOSE: begin
        close_pos = cur;
        line_st   = nx;
        return 1'b0;
      end
      csvfs_pkg::ST_PLAIN, csvfs_pkg::ST_QUOTED: begin
        if (!field_live) begin
          open_start = cur;
          field_live = 1'b1;
        end
        line_st = nx;
        return 1'b0;
      end
      csvfs_pkg::ST_QUOTE_OPEN: begin
        line_st = nx;
        return 1'b0;
      end
      csvfs_pkg::ST_QUOTE_ERR: begin
        r.row_last = 1'b1;
        r.status   = csvfs_pkg::STAT_OPEN_QUOTE;
        restart_line();
        return 1'b1;
      end
      default: begin
        if (field_live) begin
          // a closing quote that is unset or lies before the field start does not count
          stop = close_pos;
          if (stop == 16'd0 || stop < open_start) stop = cur;
          r.field_start  = open_start;
          r.field_length = stop - open_start;
        end
        r.has_field = 1'b1;
        r.row_last  = (nx == csvfs_pkg::ST_ROW_END);
        field_live  = 1'b0;
        open_start  = '0;
        close_pos   = '0;
        if (nx == csvfs_pkg::ST_ROW_END) begin
          if (eol) restart_line();
          else     row_done = 1'b1;
        end else begin
          line_st = csvfs_pkg::ST_AFTER_SEP;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Random byte that the current settings class as plain text
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == sep_cfg || c == quote_cfg || c == csvfs_pkg::NEWLINE_CODE);
    return c;
  endfunction

  // Offer one request after an optional idle burst; predict once it is taken.
  task automatic drive_char(input logic [7:0] ch, input logic eol, input bit pinned,
                            input bit pinned_has, input csvfs_pkg::result_t pinned_res);
    bit                 has;
    csvfs_pkg::result_t res;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parsed_chars++;
    has = split_char(ch, eol, res);
    if (pinned) begin
      has = pinned_has;
      res = pinned_res;
    end
    if (has) field_q = {field_q, res};
  endtask

  task automatic put_char(input logic [7:0] ch);
    drive_char(ch, 1'b0, 1'b0, 1'b0, NO_RES);
  endtask

  task automatic put_eol();
    drive_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NO_RES);
  endtask

  // Write one register with the block idle: drain results, then allow the pipeline to settle.
  task automatic write_reg(input logic [csvfs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    in_tvalid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == csvfs_pkg::CFG_SEPARATOR)  sep_cfg = val;
    else if (idx == csvfs_pkg::CFG_QUOTE) quote_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  // One random line. Mostly well-formed rows of plain, quoted and empty fields; some noise,
  // some rows closed by a newline with trailing junk, some left inside an open quote.
  task automatic send_line();
    int unsigned n_fields;
    int unsigned kind;
    int unsigned ending;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        drive_char(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0), 1'b0, 1'b0,
                   NO_RES);
      return;
    end
    n_fields = $urandom_range(0, 5);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) put_char(sep_cfg);
      kind = $urandom_range(0, 3);
      if (kind == 1) begin
        repeat ($urandom_range(1, 6)) put_char(plain_char());
      end else if (kind == 2) begin
        put_char(quote_cfg);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: begin
              put_char(quote_cfg);
              put_char(quote_cfg);
            end
            1:       put_char(sep_cfg);
            2:       put_char(csvfs_pkg::NEWLINE_CODE);
            default: put_char(plain_char());
          endcase
        end
        put_char(quote_cfg);
        if ($urandom_range(0, 3) == 0) put_char(plain_char());
      end else if (kind == 3) begin
        repeat ($urandom_range(1, 4))
          put_char(($urandom_range(0, 3) == 0) ? quote_cfg : plain_char());
      end
    end
    ending = $urandom_range(0, 9);
    if (ending < 5) begin
      put_char(csvfs_pkg::NEWLINE_CODE);
      repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(0, 255)));
    end else if (ending == 9) begin
      put_char(quote_cfg);
      put_char(plain_char());
    end
    put_eol();
  endtask

  // Result side: random stall bursts, none once no_idle is set.
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_hold   <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = {out_tdata[15:0], out_tdata[31:16], out_tuser[0], out_tlast, out_tuser[2:1]};
      if (field_q.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t: unexpected result start=%0d len=%0d has=%0b last=%0b status=%0d",
                   $time, seen_res.field_start, seen_res.field_length, seen_res.has_field,
                   seen_res.row_last, seen_res.status);
        mismatch_cnt++;
      end else begin
        want_res = field_q.pop_front();
        if (seen_res !== want_res) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display({"%0t: mismatch start %0d/%0d len %0d/%0d has %0b/%0b last %0b/%0b",
                      " status %0d/%0d (expected/actual)"}, $time,
                     want_res.field_start, seen_res.field_start,
                     want_res.field_length, seen_res.field_length,
                     want_res.has_field, seen_res.has_field,
                     want_res.row_last, seen_res.row_last,
                     want_res.status, seen_res.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    restart_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset settings
    for (int i = 0; i < NUM_PROBES; i++)
      drive_char(PROBES[i].ch, PROBES[i].eol, PROBES[i].pinned, PROBES[i].has,
                 PROBES[i].res);

    // Random phases, one register setting each; the last runs without idling.
    parsed_chars = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(csvfs_pkg::CFG_SEPARATOR, SEP_SET[p]);
      write_reg(csvfs_pkg::CFG_QUOTE, QUOTE_SET[p]);
      if (p == NUM_PHASES - 1) no_idle = 1'b1;
      while (parsed_chars < (p + 1) * RANDOM_ITEMS / NUM_PHASES) send_line();
    end

    in_tvalid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
